### hw/rtl/assert_macros.svh
// Assertion macros used by the top-level RTL file of the accumulator execute unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Condition must hold at every clock edge out of reset.
`define ACU_ASSERT_HOLD(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);
// Antecedent at one edge requires the consequent at the next edge.
`define ACU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define ACU_ASSERT_HOLD(lbl, expr, msg)
`define ACU_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

### hw/rtl/acu_pkg.sv
// Types, codes and helpers for the accumulator execute unit.
`timescale 1ns / 1ps
`default_nettype none
package acu_pkg;

  localparam int ACU_MEM_WORDS = 4096;
  localparam int PC_W          = 12;
  localparam logic [31:0] SP_RESET = 32'd4095;

  typedef enum logic [7:0] {
    OP_LDC  = 8'd0,
    OP_ADC  = 8'd1,
    OP_LDL  = 8'd2,
    OP_STL  = 8'd3,
    OP_LDNL = 8'd4,
    OP_STNL = 8'd5,
    OP_ADD  = 8'd6,
    OP_SUB  = 8'd7,
    OP_SHL  = 8'd8,
    OP_SHR  = 8'd9,
    OP_ADJ  = 8'd10,
    OP_A2SP = 8'd11,
    OP_SP2A = 8'd12,
    OP_CALL = 8'd13,
    OP_RET  = 8'd14,
    OP_BRZ  = 8'd15,
    OP_BRLZ = 8'd16,
    OP_BR   = 8'd17,
    OP_HALT = 8'd18
  } op_t;

  typedef enum logic [2:0] {
    ST_OK    = 3'd0,
    ST_HALT  = 3'd1,
    ST_PC    = 3'd2,
    ST_MEM   = 3'd3,
    ST_LOOP  = 3'd4,
    ST_BADOP = 3'd5
  } status_t;

  // architectural register state
  typedef struct packed {
    logic [31:0]     a;
    logic [31:0]     b;
    logic [PC_W-1:0] pc;
    logic [31:0]     sp;
    status_t         stop;
  } arch_t;

  // sign-extended 24-bit operand from bits 31..8
  function automatic logic [31:0] operand_ext(input logic [31:0] word);
    operand_ext = {{8{word[31]}}, word[31:8]};
  endfunction

endpackage
`default_nettype wire

### hw/rtl/acu_dmem.sv
// Data memory with one read and one write port and a zeroing sweep after reset.
`timescale 1ns / 1ps
`default_nettype none
module acu_dmem
  import acu_pkg::*;
#(
  parameter int MEM_WORDS = ACU_MEM_WORDS,
  localparam int AW = $clog2(MEM_WORDS)
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          rd_en,
  input  wire logic [AW-1:0] rd_addr,
  output logic      [31:0]   rd_data,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire logic [31:0]   wr_data,
  output logic               clr_busy
);

  logic [31:0]   mem [MEM_WORDS];
  logic [31:0]   rd_data_r;
  logic          clr_busy_r;
  logic [AW-1:0] clr_addr_r;
  logic          we;
  logic [AW-1:0] wa;
  logic [31:0]   wd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_addr_r <= '0;
    end else if (clr_busy_r) begin
      clr_addr_r <= clr_addr_r + 1'b1;
      if (clr_addr_r == AW'(MEM_WORDS - 1)) begin
        clr_busy_r <= 1'b0;
      end
    end
  end

  assign we = clr_busy_r | wr_en;
  assign wa = clr_busy_r ? clr_addr_r : wr_addr;
  assign wd = clr_busy_r ? 32'd0 : wr_data;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data  = rd_data_r;
  assign clr_busy = clr_busy_r;

endmodule
`default_nettype wire

### hw/rtl/acu_exec.sv
// Instruction execute logic: next register state, status and store request.
`timescale 1ns / 1ps
`default_nettype none
module acu_exec
  import acu_pkg::*;
(
  input  wire logic        active,
  input  arch_t            cur,
  input  wire logic [31:0] word,
  input  wire logic [31:0] rdata,
  input  wire logic        addr_ok,
  output arch_t            nxt,
  output logic             mem_we,
  output logic      [31:0] mem_wdata
);

  logic [7:0]      op;
  logic [31:0]     opd_u;
  logic [12:0]     pc1;
  logic [32:0]     tgt;
  logic [31:0]     a_n;
  logic [31:0]     b_n;
  logic [31:0]     sp_n;
  logic [PC_W-1:0] pc_n;
  logic            branch;
  logic            we_n;
  status_t         code;
  logic            commit;

  assign op    = word[7:0];
  assign opd_u = operand_ext(word);
  assign pc1   = {1'b0, cur.pc} + 13'd1;
  assign tgt   = {21'd0, pc1[11:0]} + {opd_u[31], opd_u};

  always_comb begin
    a_n       = cur.a;
    b_n       = cur.b;
    sp_n      = cur.sp;
    pc_n      = pc1[11:0];
    branch    = 1'b0;
    we_n      = 1'b0;
    mem_wdata = cur.a;
    code      = ST_OK;
    if (pc1[12]) begin
      code = ST_PC;
    end else begin
      case (op)
        OP_LDC: begin
          b_n = cur.a;
          a_n = opd_u;
        end
        OP_ADC:  a_n = cur.a + opd_u;
        OP_LDL: begin
          if (!addr_ok) begin
            code = ST_MEM;
          end else begin
            b_n = cur.a;
            a_n = rdata;
          end
        end
        OP_STL: begin
          if (!addr_ok) begin
            code = ST_MEM;
          end else begin
            we_n      = 1'b1;
            mem_wdata = cur.a;
            a_n       = cur.b;
          end
        end
        OP_LDNL: begin
          if (!addr_ok) code = ST_MEM;
          else a_n = rdata;
        end
        OP_STNL: begin
          if (!addr_ok) begin
            code = ST_MEM;
          end else begin
            we_n      = 1'b1;
            mem_wdata = cur.b;
          end
        end
        OP_ADD:  a_n = cur.a + cur.b;
        OP_SUB:  a_n = cur.b - cur.a;
        OP_SHL:  a_n = cur.b << cur.a[4:0];
        OP_SHR:  a_n = $unsigned($signed(cur.b) >>> cur.a[4:0]);
        OP_ADJ:  sp_n = cur.sp + opd_u;
        OP_A2SP: begin
          sp_n = cur.a;
          a_n  = cur.b;
        end
        OP_SP2A: begin
          b_n = cur.a;
          a_n = cur.sp;
        end
        OP_CALL: begin
          b_n    = cur.a;
          a_n    = {20'd0, pc1[11:0]};
          branch = 1'b1;
        end
        OP_RET: begin
          // return to itself with A == B is a hang
          if (cur.a == cur.b && cur.a == {20'd0, cur.pc}) begin
            code = ST_LOOP;
          end else if (cur.a[31:12] != 20'd0) begin
            code = ST_PC;
          end else begin
            pc_n = cur.a[11:0];
            a_n  = cur.b;
          end
        end
        OP_BRZ:  branch = (cur.a == 32'd0);
        OP_BRLZ: branch = cur.a[31];
        OP_BR:   branch = 1'b1;
        OP_HALT: code = ST_HALT;
        default: code = ST_BADOP;
      endcase
      if (branch) begin
        if (opd_u == 32'hFFFF_FFFF) begin
          code = ST_LOOP;
        end else if (tgt[32:12] != 21'd0) begin
          code = ST_PC;
        end else begin
          pc_n = tgt[11:0];
        end
      end
    end
  end

  assign commit = active && (code == ST_OK || code == ST_HALT);

  always_comb begin
    nxt = cur;
    if (commit) begin
      nxt.a  = a_n;
      nxt.b  = b_n;
      nxt.sp = sp_n;
      nxt.pc = pc_n;
    end
    if (active) begin
      nxt.stop = code;
    end
  end

  assign mem_we = commit && we_n;

endmodule
`default_nettype wire

### hw/rtl/accumulator_cpu_execute_unit.sv
// Top level of the accumulator execute unit: pipeline, hazards and result register.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
// Executes a two-register accumulator machine (A, B, PC, SP, data memory, sticky
// stop status). Every accepted item gives one result: the register state and
// status after it. Load items (in_load_item = 1) write in_word into data memory and
// flow at one item per cycle while out_stall is low. Execute items issue the data
// memory read from the committed SP or A in stage 1, execute and commit in stage 2,
// and the next execute item waits for that commit since its address depends on it.
// A load just ahead of an execute item is forwarded into the read data. After reset
// the memory is zeroed by a sweep of all MEM_WORDS words; in_stall is high meanwhile.
// Once the status is nonzero, execute items change nothing; loads still write.
// The output register lets a new item enter while a result waits on out_stall.
module accumulator_cpu_execute_unit
  import acu_pkg::*;
#(
  parameter int MEM_WORDS = ACU_MEM_WORDS
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        in_load_item,
  input  wire logic [11:0] in_mem_address,
  input  wire logic [31:0] in_word,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic signed [31:0] out_acc_a,
  output logic signed [31:0] out_acc_b,
  output logic      [11:0] out_prog_pc,
  output logic signed [31:0] out_stack_ptr,
  output logic      [2:0]  out_status
);

  localparam int AW = $clog2(MEM_WORDS);

  // stage 1: accepted item, address generation and memory read issue
  logic          s1_v_r;
  logic          s1_load_r;
  logic [11:0]   s1_maddr_r;
  logic [31:0]   s1_word_r;
  // stage 2: execute and commit
  logic          s2_v_r;
  logic          s2_load_r;
  logic [11:0]   s2_maddr_r;
  logic [31:0]   s2_word_r;
  logic [AW-1:0] s2_aidx_r;
  logic          s2_aok_r;
  // load-to-read forwarding
  logic          fwd_r;
  logic [31:0]   fwd_data_r;
  logic          fwd_nxt;

  arch_t         arch_r;
  arch_t         exec_nxt;
  logic          out_v_r;
  arch_t         out_r;

  logic          clr_busy;
  logic          in_acc;
  logic          s1_go;
  logic          s2_go;
  logic [31:0]   s1_base;
  logic [32:0]   s1_addr;
  logic          s1_aok;
  logic          s1_memop;
  logic [AW-1:0] s1_aidx;
  logic [AW-1:0] s2_lidx;
  logic          s2_lok;
  logic [31:0]   mem_rdata;
  logic [31:0]   exec_rdata;
  logic          exec_we;
  logic [31:0]   exec_wdata;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [31:0]   wr_data;

  // handshake
  assign s2_go    = s2_v_r && (!out_v_r || !out_stall);
  // an execute item reads committed state, so it waits for an execute in stage 2
  assign s1_go    = s1_v_r && (!s2_v_r || s2_go) && (s1_load_r || !s2_v_r || s2_load_r);
  assign in_stall = clr_busy || (s1_v_r && !s1_go);
  assign in_acc   = in_valid && !in_stall;

  // address generation: SP for local, A for non-local accesses
  always_comb begin
    s1_memop = 1'b0;
    s1_base  = arch_r.sp;
    case (s1_word_r[7:0])
      OP_LDL, OP_STL: begin
        s1_memop = 1'b1;
        s1_base  = arch_r.sp;
      end
      OP_LDNL, OP_STNL: begin
        s1_memop = 1'b1;
        s1_base  = arch_r.a;
      end
      default: s1_memop = 1'b0;
    endcase
  end

  assign s1_addr = {s1_base[31], s1_base} + {1'b0, operand_ext(s1_word_r)} +
                   {s1_word_r[31], 32'd0};
  assign s1_aok  = !s1_addr[32] && (s1_addr < 33'(MEM_WORDS));
  assign s1_aidx = s1_addr[AW-1:0];

  // load item write target
  assign s2_lidx = AW'(s2_maddr_r);
  assign s2_lok  = 32'(s2_maddr_r) < 32'(MEM_WORDS);

  // a load to the same address leaving stage 2 in the same edge as the read is issued
  assign fwd_nxt = !s1_load_r && s2_go && s2_load_r && s2_lok && (s2_lidx == s1_aidx);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      out_v_r <= 1'b0;
      fwd_r   <= 1'b0;
      arch_r  <= '{a: 32'd0, b: 32'd0, pc: '0, sp: SP_RESET, stop: ST_OK};
    end else begin
      if (in_acc) begin
        s1_v_r <= 1'b1;
      end else if (s1_go) begin
        s1_v_r <= 1'b0;
      end
      if (s1_go) begin
        s2_v_r <= 1'b1;
        fwd_r  <= fwd_nxt;
      end else if (s2_go) begin
        s2_v_r <= 1'b0;
      end
      if (s2_go) begin
        out_v_r <= 1'b1;
      end else if (!out_stall) begin
        out_v_r <= 1'b0;
      end
      if (s2_go && !s2_load_r) begin
        arch_r <= exec_nxt;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_load_r  <= in_load_item;
      s1_maddr_r <= in_mem_address;
      s1_word_r  <= in_word;
    end
    if (s1_go) begin
      s2_load_r  <= s1_load_r;
      s2_maddr_r <= s1_maddr_r;
      s2_word_r  <= s1_word_r;
      s2_aidx_r  <= s1_aidx;
      s2_aok_r   <= s1_aok;
      fwd_data_r <= s2_word_r;
    end
    if (s2_go) begin
      out_r <= s2_load_r ? arch_r : exec_nxt;
    end
  end

  acu_dmem #(
    .MEM_WORDS(MEM_WORDS)
  ) u_dmem (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_en    (s1_go && !s1_load_r && s1_memop && s1_aok),
    .rd_addr  (s1_aidx),
    .rd_data  (mem_rdata),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_data  (wr_data),
    .clr_busy (clr_busy)
  );

  assign exec_rdata = fwd_r ? fwd_data_r : mem_rdata;

  acu_exec u_exec (
    .active    (s2_v_r && !s2_load_r && arch_r.stop == ST_OK),
    .cur       (arch_r),
    .word      (s2_word_r),
    .rdata     (exec_rdata),
    .addr_ok   (s2_aok_r),
    .nxt       (exec_nxt),
    .mem_we    (exec_we),
    .mem_wdata (exec_wdata)
  );

  // memory write: load item word, or a committed store
  assign wr_en   = s2_go && (s2_load_r ? s2_lok : exec_we);
  assign wr_addr = s2_load_r ? s2_lidx : s2_aidx_r;
  assign wr_data = s2_load_r ? s2_word_r : exec_wdata;

  assign out_valid     = out_v_r;
  assign out_acc_a     = $signed(out_r.a);
  assign out_acc_b     = $signed(out_r.b);
  assign out_prog_pc   = out_r.pc;
  assign out_stack_ptr = $signed(out_r.sp);
  assign out_status    = out_r.stop;

  // no item may enter while memory is being zeroed
  `ACU_ASSERT_HOLD(a_no_accept_in_clear, !(in_acc && clr_busy), "item accepted during clear")
  // a stop status never changes once set
  `ACU_ASSERT_NEXT(a_stop_sticky, arch_r.stop != ST_OK, arch_r.stop == $past(arch_r.stop), "stop status changed")
  // forwarded data only ever feeds an execute item
  `ACU_ASSERT_HOLD(a_fwd_exec, !(fwd_r && s2_v_r && s2_load_r), "forward flag on a load item")

endmodule
`default_nettype wire
